// ===== rtl/jdmc_pkg.sv =====
package jdmc_pkg;

  // Default payload widths
  localparam int unsigned AXIS_BITS_DEF = 8;
  localparam int unsigned TIME_BITS_DEF = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned FULL_W     = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTROL_PERIOD  = 3'd0,
    REG_DISPLAY_PERIOD  = 3'd1,
    REG_MESSAGE_TIME    = 3'd2,
    REG_DEBOUNCE_TIME   = 3'd3,
    REG_FULL_SCALE      = 3'd4,
    REG_DISPLAY_PRESENT = 3'd5
  } cfg_reg_e;

  // Register reset values
  localparam logic [PERIOD_W-1:0] CONTROL_PERIOD_RST = 16'd30;
  localparam logic [PERIOD_W-1:0] DISPLAY_PERIOD_RST = 16'd250;
  localparam logic [PERIOD_W-1:0] MESSAGE_TIME_RST   = 16'd2000;
  localparam logic [PERIOD_W-1:0] DEBOUNCE_TIME_RST  = 16'd150;
  localparam logic [FULL_W-1:0]   FULL_SCALE_RST     = 7'd127;

  // Screen selection codes
  localparam int unsigned SCREEN_W = 3;

  typedef enum logic [SCREEN_W-1:0] {
    SCR_NONE    = 3'd0,
    SCR_MAIN    = 3'd1,
    SCR_DETAILS = 3'd2,
    SCR_MESSAGE = 3'd3,
    SCR_FAULT   = 3'd4
  } screen_e;

endpackage

// ===== rtl/jdmc_if.sv =====
// Poll channel: one joystick/button/fault sample per item
interface jdmc_in_if import jdmc_pkg::*; #(
  parameter int unsigned AXIS_BITS = AXIS_BITS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic [TIME_BITS-1:0]        time_ms;
  logic signed [AXIS_BITS-1:0] axis_x;
  logic signed [AXIS_BITS-1:0] axis_y;
  logic signed [AXIS_BITS-1:0] axis_z;
  logic                        button_page;
  logic                        button_mode;
  logic                        fault_a;
  logic                        fault_b;

  modport source (
    output valid, time_ms, axis_x, axis_y, axis_z,
    output button_page, button_mode, fault_a, fault_b,
    input  ready
  );

  modport sink (
    input  valid, time_ms, axis_x, axis_y, axis_z,
    input  button_page, button_mode, fault_a, fault_b,
    output ready
  );
endinterface

// Result channel: motor commands and screen selection
interface jdmc_out_if import jdmc_pkg::*; #(
  parameter int unsigned AXIS_BITS = AXIS_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [AXIS_BITS-1:0] power_a;
  logic signed [AXIS_BITS-1:0] power_b;
  logic                        rotation_mode;
  logic [SCREEN_W-1:0]         screen;

  modport source (
    output valid, power_a, power_b, rotation_mode, screen,
    input  ready
  );

  modport sink (
    input  valid, power_a, power_b, rotation_mode, screen,
    output ready
  );
endinterface

// ===== rtl/joystick_drive_mode_controller.sv =====
// Joystick drive-mode controller with differential steering mix.
//
// in_if carries one poll per item (time, three axes, two buttons, two fault
// flags); out_if returns at most one result per poll (two motor commands,
// drive mode, screen code). Both use valid/ready. The cfg_* port writes the
// six timing/scale registers; the user is to write them only while the
// block is idle, as the block itself does not enforce this. The block works
// on one poll at a time and is ready only in its idle state. A poll that
// falls inside the control period gives no result; the block goes from its
// evaluation state straight back to idle. The first poll after reset goes
// from evaluation straight to emit. A rotation-mode step runs evaluation,
// multiply, screen and emit; a normal-mode step adds the divide state, a
// restoring inner-motor divider by full_scale: one quotient bit per cycle.
// The result sits in an output register; the next poll is accepted while it
// waits, and its own result holds in the sequencer until out_if.ready frees
// the register. Reset clears all state and loads the register defaults; the
// first poll afterwards does the start-up capture.
module joystick_drive_mode_controller import jdmc_pkg::*; #(
  parameter int unsigned AXIS_BITS = AXIS_BITS_DEF,
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  jdmc_in_if.sink               in_if,
  jdmc_out_if.source            out_if
);

  // Divider geometry
  localparam int unsigned MW = (AXIS_BITS > 8) ? AXIS_BITS : 8; // |full - |x||
  localparam int unsigned DW = MW + 1;                          // full - |x|
  localparam int unsigned PW = AXIS_BITS + MW;                  // |y * d|
  localparam int unsigned CW = $clog2(PW);

  localparam logic [AXIS_BITS-1:0] AXIS_MAX  = {1'b0, {(AXIS_BITS-1){1'b1}}};
  localparam logic [AXIS_BITS-1:0] AXIS_MIN  = {1'b1, {(AXIS_BITS-1){1'b0}}};
  localparam logic [AXIS_BITS-1:0] AXIS_NMAX = AXIS_MIN | {{(AXIS_BITS-1){1'b0}}, 1'b1};

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_SCR,
    S_EMIT
  } state_e;

  // Configuration registers
  logic [PERIOD_W-1:0] ctrl_per_q, disp_per_q, msg_time_q, deb_q;
  logic [FULL_W-1:0]   full_q;
  logic                disp_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_per_q <= CONTROL_PERIOD_RST;
      disp_per_q <= DISPLAY_PERIOD_RST;
      msg_time_q <= MESSAGE_TIME_RST;
      deb_q      <= DEBOUNCE_TIME_RST;
      full_q     <= FULL_SCALE_RST;
      disp_en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CONTROL_PERIOD:  ctrl_per_q <= cfg_data_i;
        REG_DISPLAY_PERIOD:  disp_per_q <= cfg_data_i;
        REG_MESSAGE_TIME:    msg_time_q <= cfg_data_i;
        REG_DEBOUNCE_TIME:   deb_q      <= cfg_data_i;
        REG_FULL_SCALE:      full_q     <= cfg_data_i[FULL_W-1:0];
        REG_DISPLAY_PRESENT: disp_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer, controller state and datapath registers
  state_e               state_q;
  logic                 started_q, prev_page_q, prev_mode_q, armed_q;
  logic                 mode_q, detail_q, msg_q, force_q;
  logic [TIME_BITS-1:0] last_ctrl_q, last_ref_q, msg_start_q, last_press_q;

  logic [TIME_BITS-1:0] now_q;
  logic [AXIS_BITS-1:0] x_q, y_q, z_q;
  logic                 bpage_q, bmode_q, fault_q;

  logic [AXIS_BITS-1:0] mag_y_q;
  logic [MW-1:0]        mag_d_q;
  logic                 neg_q;
  logic [PW-1:0]        dq_q;
  logic [FULL_W-1:0]    rem_q;
  logic [CW-1:0]        cnt_q;

  logic [AXIS_BITS-1:0] res_pa_q, res_pb_q;
  logic                 res_rot_q;
  screen_e              res_scr_q;

  logic                 out_valid_q;
  logic [AXIS_BITS-1:0] out_pa_q, out_pb_q;
  logic                 out_rot_q;
  screen_e              out_scr_q;

  // Elapsed times, modulo 2^TIME_BITS
  logic [TIME_BITS-1:0] ctrl_el, press_el, ref_el, msg_el;
  assign ctrl_el  = now_q - last_ctrl_q;
  assign press_el = now_q - last_press_q;
  assign ref_el   = now_q - last_ref_q;
  assign msg_el   = now_q - msg_start_q;

  logic ctrl_due, deb_ok, ref_due, msg_live;
  assign ctrl_due = ctrl_el >= TIME_BITS'(ctrl_per_q);
  assign deb_ok   = press_el >= TIME_BITS'(deb_q);
  assign ref_due  = ref_el >= TIME_BITS'(disp_per_q);
  assign msg_live = msg_el < TIME_BITS'(msg_time_q);

  // Steering operands: |y|, |full - |x||, and sign of the product
  logic [FULL_W-1:0]    full_eff;
  logic [AXIS_BITS-1:0] ax, ay;
  logic [DW-1:0]        d_s, d_abs;
  assign full_eff = (full_q == '0) ? FULL_W'(1) : full_q;
  assign ax       = x_q[AXIS_BITS-1] ? (~x_q + 1'b1) : x_q;
  assign ay       = y_q[AXIS_BITS-1] ? (~y_q + 1'b1) : y_q;
  assign d_s      = DW'(full_eff) - DW'(ax);
  assign d_abs    = d_s[DW-1] ? (~d_s + 1'b1) : d_s;

  // One restoring division step
  logic [FULL_W:0] trial;
  logic            trial_ge;
  assign trial    = {rem_q, dq_q[PW-1]};
  assign trial_ge = trial >= {1'b0, full_eff};

  // Saturated commands
  logic [AXIS_BITS-1:0] q_sat, reduced, sat_y, sat_z, sat_nz;
  assign q_sat   = (dq_q > {{MW{1'b0}}, AXIS_MAX}) ? AXIS_MAX : dq_q[AXIS_BITS-1:0];
  assign reduced = neg_q ? (~q_sat + 1'b1) : q_sat;
  assign sat_y   = (y_q == AXIS_MIN) ? AXIS_NMAX : y_q;
  assign sat_z   = (z_q == AXIS_MIN) ? AXIS_NMAX : z_q;
  assign sat_nz  = (z_q == AXIS_MIN) ? AXIS_MAX : (~z_q + 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      started_q    <= 1'b0;
      prev_page_q  <= 1'b0;
      prev_mode_q  <= 1'b0;
      armed_q      <= 1'b0;
      mode_q       <= 1'b0;
      detail_q     <= 1'b0;
      msg_q        <= 1'b0;
      force_q      <= 1'b1;
      last_ctrl_q  <= '0;
      last_ref_q   <= '0;
      msg_start_q  <= '0;
      last_press_q <= '0;
      now_q        <= '0;
      x_q          <= '0;
      y_q          <= '0;
      z_q          <= '0;
      bpage_q      <= 1'b0;
      bmode_q      <= 1'b0;
      fault_q      <= 1'b0;
      mag_y_q      <= '0;
      mag_d_q      <= '0;
      neg_q        <= 1'b0;
      dq_q         <= '0;
      rem_q        <= '0;
      cnt_q        <= '0;
      res_pa_q     <= '0;
      res_pb_q     <= '0;
      res_rot_q    <= 1'b0;
      res_scr_q    <= SCR_NONE;
      out_valid_q  <= 1'b0;
      out_pa_q     <= '0;
      out_pb_q     <= '0;
      out_rot_q    <= 1'b0;
      out_scr_q    <= SCR_NONE;
    end else begin
      // Output register drains when taken, unless a new result is loaded
      if (out_valid_q && out_if.ready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        // Capture the poll
        S_IDLE: begin
          if (in_if.valid) begin
            now_q   <= in_if.time_ms;
            x_q     <= in_if.axis_x;
            y_q     <= in_if.axis_y;
            z_q     <= in_if.axis_z;
            bpage_q <= in_if.button_page;
            bmode_q <= in_if.button_mode;
            fault_q <= in_if.fault_a | in_if.fault_b;
            state_q <= S_EVAL;
          end
        end

        // Start-up capture, control period gate, button handling
        S_EVAL: begin
          mag_y_q <= ay;
          mag_d_q <= d_abs[MW-1:0];
          neg_q   <= y_q[AXIS_BITS-1] ^ d_s[DW-1];
          if (!started_q) begin
            started_q    <= 1'b1;
            mode_q       <= 1'b0;
            detail_q     <= 1'b0;
            msg_q        <= 1'b0;
            prev_page_q  <= bpage_q;
            prev_mode_q  <= bmode_q;
            armed_q      <= ~bmode_q;
            last_ctrl_q  <= now_q;
            last_ref_q   <= now_q;
            last_press_q <= now_q - TIME_BITS'(deb_q);
            res_pa_q     <= '0;
            res_pb_q     <= '0;
            res_rot_q    <= 1'b0;
            if (disp_en_q) begin
              force_q   <= 1'b0;
              res_scr_q <= SCR_MAIN;
            end else begin
              res_scr_q <= SCR_NONE;
            end
            state_q <= S_EMIT;
          end else if (!ctrl_due) begin
            state_q <= S_IDLE;
          end else begin
            last_ctrl_q <= now_q;
            // page button rising edge, ignored while the message shows
            if (!msg_q && bpage_q && !prev_page_q) begin
              detail_q <= ~detail_q;
              force_q  <= 1'b1;
            end
            prev_page_q <= bpage_q;
            // mode button: rearm on release, debounced rising edge toggles
            if (!armed_q) begin
              if (!bmode_q) begin
                armed_q <= 1'b1;
              end
            end else if (bmode_q && !prev_mode_q && deb_ok) begin
              last_press_q <= now_q;
              mode_q       <= ~mode_q;
              msg_q        <= 1'b1;
              msg_start_q  <= now_q;
              detail_q     <= 1'b0;
              force_q      <= 1'b1;
            end
            prev_mode_q <= bmode_q;
            state_q     <= S_MUL;
          end
        end

        // Rotation commands, or the steering product magnitude
        S_MUL: begin
          if (mode_q) begin
            res_pa_q <= sat_z;
            res_pb_q <= sat_nz;
            state_q  <= S_SCR;
          end else begin
            dq_q    <= {{MW{1'b0}}, mag_y_q} * {{AXIS_BITS{1'b0}}, mag_d_q};
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end

        // One quotient bit per cycle
        S_DIV: begin
          rem_q <= trial_ge ? FULL_W'(trial - {1'b0, full_eff}) : trial[FULL_W-1:0];
          dq_q  <= {dq_q[PW-2:0], trial_ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(PW - 1)) begin
            state_q <= S_SCR;
          end
        end

        // Pick outer/inner motor and the screen
        S_SCR: begin
          res_rot_q <= mode_q;
          if (!mode_q) begin
            if (!x_q[AXIS_BITS-1]) begin
              res_pa_q <= sat_y;
              res_pb_q <= reduced;
            end else begin
              res_pa_q <= reduced;
              res_pb_q <= sat_y;
            end
          end
          if (disp_en_q && (force_q || ref_due)) begin
            last_ref_q <= now_q;
            force_q    <= 1'b0;
            if (fault_q) begin
              res_scr_q <= SCR_FAULT;
            end else if (msg_q && msg_live) begin
              res_scr_q <= SCR_MESSAGE;
            end else begin
              // message expiry returns to the main page
              if (msg_q) begin
                msg_q    <= 1'b0;
                detail_q <= 1'b0;
              end
              res_scr_q <= (detail_q && !msg_q) ? SCR_DETAILS : SCR_MAIN;
            end
          end else begin
            res_scr_q <= SCR_NONE;
          end
          state_q <= S_EMIT;
        end

        // Hand the result to the output register once it is free
        S_EMIT: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q <= 1'b1;
            out_pa_q    <= res_pa_q;
            out_pb_q    <= res_pb_q;
            out_rot_q   <= res_rot_q;
            out_scr_q   <= res_scr_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_if.ready          = (state_q == S_IDLE);
  assign out_if.valid         = out_valid_q;
  assign out_if.power_a       = out_pa_q;
  assign out_if.power_b       = out_pb_q;
  assign out_if.rotation_mode = out_rot_q;
  assign out_if.screen        = out_scr_q;

  // Start-up capture happens once per reset
  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag dropped");

  // Divider never runs past its bit count
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q <= CW'(PW - 1)))
    else $error("divider count out of range");

  // A new result is only loaded from the emit step
  a_load_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_EMIT))
    else $error("result loaded outside emit step");

endmodule

// ===== sim/joystick_drive_mode_controller_tb.sv =====
module joystick_drive_mode_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jdmc_pkg::*;

  localparam int AXIS_W      = AXIS_BITS_DEF;
  localparam int TIME_W      = TIME_BITS_DEF;
  localparam int AXIS_MAX    = 2 ** (AXIS_W - 1) - 1;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [TIME_W-1:0]        time_ms;
    logic signed [AXIS_W-1:0] axis_x;
    logic signed [AXIS_W-1:0] axis_y;
    logic signed [AXIS_W-1:0] axis_z;
    logic                     button_page;
    logic                     button_mode;
    logic                     fault_a;
    logic                     fault_b;
  } poll_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] power_a;
    logic signed [AXIS_W-1:0] power_b;
    logic                     rotation_mode;
    screen_e                  screen;
  } drive_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  jdmc_in_if  #(.AXIS_BITS(AXIS_W), .TIME_BITS(TIME_W)) poll_if ();
  jdmc_out_if #(.AXIS_BITS(AXIS_W))                     drive_if ();

  joystick_drive_mode_controller #(
    .AXIS_BITS(AXIS_W),
    .TIME_BITS(TIME_W)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (poll_if),
    .out_if    (drive_if)
  );

  // Register copies, as the block should hold them
  logic [PERIOD_W-1:0] ctl_period;
  logic [PERIOD_W-1:0] disp_period;
  logic [PERIOD_W-1:0] msg_time;
  logic [PERIOD_W-1:0] deb_time;
  logic [FULL_W-1:0]   full_scale_r;
  logic                disp_on;

  // Controller state
  logic              started, prev_page, prev_mode, mode_armed;
  logic              mode_rot, detail_pg, msg_on, refresh_due;
  logic [TIME_W-1:0] last_ctl_ms, last_refresh_ms, msg_start_ms, last_press_ms;

  poll_t  poll_q[$];
  drive_t drive_exp_q[$];
  poll_t  poll_next;
  poll_t  poll_seen;
  drive_t drive_pred;
  drive_t drive_want;

  logic [TIME_W-1:0] cur_time;
  logic              page_lvl, mode_lvl;
  logic              calm;
  int                poll_gap, stall_left;
  int                err_cnt, cycle_cnt;

  // Clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic int clip(int v);
    if (v > AXIS_MAX) return AXIS_MAX;
    if (v < -AXIS_MAX) return -AXIS_MAX;
    return v;
  endfunction

  // One poll through the controller; returns 1 when it yields a drive result
  function automatic bit mix_poll(input poll_t p, output drive_t r);
    int                x, y, z, full, ax, pa, pb;
    logic [TIME_W-1:0] now;
    screen_e           scr;
    now = p.time_ms;
    x   = int'(p.axis_x);
    y   = int'(p.axis_y);
    z   = int'(p.axis_z);
    scr = SCR_NONE;
    pa  = 0;
    pb  = 0;
    r   = '0;
    if (!started) begin
      // start-up capture
      started       = 1'b1;
      mode_rot      = 1'b0;
      detail_pg     = 1'b0;
      msg_on        = 1'b0;
      prev_page     = p.button_page;
      prev_mode     = p.button_mode;
      mode_armed    = !p.button_mode;
      if (disp_on) begin
        refresh_due = 1'b0;
        scr         = SCR_MAIN;
      end
      last_ctl_ms     = now;
      last_refresh_ms = now;
      last_press_ms   = now - TIME_W'(deb_time);
    end else begin
      if (TIME_W'(now - last_ctl_ms) < TIME_W'(ctl_period)) return 1'b0;
      last_ctl_ms = now;

      // page button, ignored while the mode message shows
      if (!msg_on && p.button_page && !prev_page) begin
        detail_pg   = !detail_pg;
        refresh_due = 1'b1;
      end
      prev_page = p.button_page;

      // mode button: re-arm on release, then debounced rising edge
      if (!mode_armed) begin
        if (!p.button_mode) mode_armed = 1'b1;
      end else if (p.button_mode && !prev_mode &&
                   TIME_W'(now - last_press_ms) >= TIME_W'(deb_time)) begin
        last_press_ms = now;
        mode_rot      = !mode_rot;
        msg_on        = 1'b1;
        msg_start_ms  = now;
        detail_pg     = 1'b0;
        refresh_due   = 1'b1;
      end
      prev_mode = p.button_mode;

      // motor mix
      if (mode_rot) begin
        pa = z;
        pb = -z;
      end else begin
        full = (full_scale_r == '0) ? 1 : int'(full_scale_r);
        ax   = (x < 0) ? -x : x;
        if (x >= 0) begin
          pa = y;
          pb = clip(y * (full - ax) / full);
        end else begin
          pa = clip(y * (full - ax) / full);
          pb = y;
        end
      end

      // screen selection
      if (disp_on && (refresh_due ||
          TIME_W'(now - last_refresh_ms) >= TIME_W'(disp_period))) begin
        last_refresh_ms = now;
        refresh_due     = 1'b0;
        if (p.fault_a || p.fault_b) begin
          scr = SCR_FAULT;
        end else if (msg_on && TIME_W'(now - msg_start_ms) < TIME_W'(msg_time)) begin
          scr = SCR_MESSAGE;
        end else begin
          if (msg_on) begin
            msg_on    = 1'b0;
            detail_pg = 1'b0;
          end
          scr = detail_pg ? SCR_DETAILS : SCR_MAIN;
        end
      end
    end
    r.power_a       = AXIS_W'(clip(pa));
    r.power_b       = AXIS_W'(clip(pb));
    r.rotation_mode = mode_rot;
    r.screen        = scr;
    return 1'b1;
  endfunction

  task automatic report(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Poll driver
  always @(posedge clk_i) begin
    if (!poll_if.valid || poll_if.ready) begin
      if (poll_gap != 0) begin
        poll_gap = poll_gap - 1;
        poll_if.valid <= 1'b0;
      end else if (rst_ni && poll_q.size() != 0) begin
        poll_next = poll_q.pop_front();
        poll_if.valid       <= 1'b1;
        poll_if.time_ms     <= poll_next.time_ms;
        poll_if.axis_x      <= poll_next.axis_x;
        poll_if.axis_y      <= poll_next.axis_y;
        poll_if.axis_z      <= poll_next.axis_z;
        poll_if.button_page <= poll_next.button_page;
        poll_if.button_mode <= poll_next.button_mode;
        poll_if.fault_a     <= poll_next.fault_a;
        poll_if.fault_b     <= poll_next.fault_b;
        if (!calm && $urandom_range(0, 5) == 0) poll_gap = $urandom_range(1, 16);
      end else begin
        poll_if.valid <= 1'b0;
      end
    end
  end

  // Accepted polls feed the prediction
  always @(posedge clk_i) begin
    if (rst_ni && poll_if.valid && poll_if.ready) begin
      poll_seen.time_ms     = poll_if.time_ms;
      poll_seen.axis_x      = poll_if.axis_x;
      poll_seen.axis_y      = poll_if.axis_y;
      poll_seen.axis_z      = poll_if.axis_z;
      poll_seen.button_page = poll_if.button_page;
      poll_seen.button_mode = poll_if.button_mode;
      poll_seen.fault_a     = poll_if.fault_a;
      poll_seen.fault_b     = poll_if.fault_b;
      if (mix_poll(poll_seen, drive_pred)) drive_exp_q.push_back(drive_pred);
    end
  end

  // Result sink with stall bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      drive_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 15);
      drive_if.ready <= 1'b0;
    end else begin
      drive_if.ready <= 1'b1;
    end
  end

  // Result check
  always @(posedge clk_i) begin
    if (rst_ni && drive_if.valid && drive_if.ready) begin
      if (drive_exp_q.size() == 0) begin
        report("unexpected result, screen", int'(drive_if.screen), -1);
      end else begin
        drive_want = drive_exp_q.pop_front();
        if (drive_if.power_a !== drive_want.power_a)
          report("power_a", int'(drive_if.power_a), int'(drive_want.power_a));
        if (drive_if.power_b !== drive_want.power_b)
          report("power_b", int'(drive_if.power_b), int'(drive_want.power_b));
        if (drive_if.rotation_mode !== drive_want.rotation_mode)
          report("rotation_mode", int'(drive_if.rotation_mode),
                 int'(drive_want.rotation_mode));
        if (drive_if.screen !== drive_want.screen)
          report("screen", int'(drive_if.screen), int'(drive_want.screen));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Wait until nothing is in flight, then let an ignored poll finish too
  task automatic wait_drained();
    do @(negedge clk_i);
    while (poll_q.size() != 0 || poll_if.valid || drive_exp_q.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_reg(cfg_reg_e idx, int val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_CONTROL_PERIOD:  ctl_period   = PERIOD_W'(val);
      REG_DISPLAY_PERIOD:  disp_period  = PERIOD_W'(val);
      REG_MESSAGE_TIME:    msg_time     = PERIOD_W'(val);
      REG_DEBOUNCE_TIME:   deb_time     = PERIOD_W'(val);
      REG_FULL_SCALE:      full_scale_r = FULL_W'(val);
      REG_DISPLAY_PRESENT: disp_on      = val[0];
      default: ;
    endcase
  endtask

  task automatic add_poll(logic [TIME_W-1:0] dt, int x, int y, int z,
                          bit bp, bit bm, bit fa, bit fb);
    poll_t p;
    cur_time      = cur_time + dt;
    p.time_ms     = cur_time;
    p.axis_x      = AXIS_W'(x);
    p.axis_y      = AXIS_W'(y);
    p.axis_z      = AXIS_W'(z);
    p.button_page = bp;
    p.button_mode = bm;
    p.fault_a     = fa;
    p.fault_b     = fb;
    poll_q.push_back(p);
  endtask

  // Axis value biased toward the extremes and the steering full scale
  function automatic int pick_axis();
    case ($urandom_range(0, 11))
      0: return -AXIS_MAX - 1;
      1: return AXIS_MAX;
      2: return -AXIS_MAX;
      3: return 0;
      4: return int'(full_scale_r);
      5: return -int'(full_scale_r);
      default: return int'($signed(AXIS_W'($urandom)));
    endcase
  endfunction

  // Random polls: mostly control steps with held buttons, some early or far polls
  task automatic gen_polls(int n);
    logic [TIME_W-1:0] dt;
    int                sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 12)
        dt = $urandom_range(0, int'(ctl_period) - 1);
      else if (sel < 16)
        dt = $urandom;
      else
        dt = ctl_period + $urandom_range(0, int'(ctl_period) / 2 + 40);
      if ($urandom_range(0, 3) == 0) page_lvl = !page_lvl;
      if ($urandom_range(0, 3) == 0) mode_lvl = !mode_lvl;
      add_poll(dt, pick_axis(), pick_axis(), pick_axis(), page_lvl, mode_lvl,
               $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
    end
  endtask

  task automatic run_phase(int cp, int dp, int mt, int deb, int full, int present, int n);
    wait_drained();
    set_reg(REG_CONTROL_PERIOD, cp);
    set_reg(REG_DISPLAY_PERIOD, dp);
    set_reg(REG_MESSAGE_TIME, mt);
    set_reg(REG_DEBOUNCE_TIME, deb);
    set_reg(REG_FULL_SCALE, full);
    set_reg(REG_DISPLAY_PRESENT, present);
    gen_polls(n);
  endtask

  // Stimulus
  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_data_i          = '0;
    poll_if.valid       = 1'b0;
    poll_if.time_ms     = '0;
    poll_if.axis_x      = '0;
    poll_if.axis_y      = '0;
    poll_if.axis_z      = '0;
    poll_if.button_page = 1'b0;
    poll_if.button_mode = 1'b0;
    poll_if.fault_a     = 1'b0;
    poll_if.fault_b     = 1'b0;
    drive_if.ready      = 1'b0;
    calm                = 1'b0;
    poll_gap            = 0;
    stall_left          = 0;
    err_cnt             = 0;
    cycle_cnt           = 0;
    page_lvl            = 1'b0;
    mode_lvl            = 1'b0;

    // reset defaults of the register copies and state
    ctl_period      = CONTROL_PERIOD_RST;
    disp_period     = DISPLAY_PERIOD_RST;
    msg_time        = MESSAGE_TIME_RST;
    deb_time        = DEBOUNCE_TIME_RST;
    full_scale_r    = FULL_SCALE_RST;
    disp_on         = 1'b1;
    started         = 1'b0;
    prev_page       = 1'b0;
    prev_mode       = 1'b0;
    mode_armed      = 1'b0;
    mode_rot        = 1'b0;
    detail_pg       = 1'b0;
    msg_on          = 1'b0;
    refresh_due     = 1'b1;
    last_ctl_ms     = '0;
    last_refresh_ms = '0;
    msg_start_ms    = '0;
    last_press_ms   = '0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed polls at reset settings; time wraps past zero early on
    cur_time = 32'hFFFF_FF80;
    add_poll(0, 0, 0, 0, 1, 1, 0, 0);          // start-up with mode button held
    add_poll(10, 5, 5, 5, 1, 1, 0, 0);         // too early, ignored
    add_poll(25, 127, 127, 0, 1, 1, 0, 0);     // still unarmed, full deflection
    add_poll(30, -128, -128, 0, 0, 0, 0, 0);   // release arms, most negative axes
    add_poll(30, 64, -100, -128, 0, 1, 0, 0);  // mode edge into rotation
    add_poll(30, 0, 0, 127, 1, 1, 0, 0);       // page edge during message
    add_poll(30, 0, 0, -1, 0, 0, 0, 0);
    add_poll(300, 0, 0, 9, 0, 0, 1, 0);        // refresh due, fault shown
    add_poll(2000, 0, 0, 5, 0, 0, 0, 0);       // message expires
    add_poll(30, 0, 0, 0, 1, 0, 0, 0);         // details page
    add_poll(30, -50, 100, 0, 0, 1, 0, 0);     // back to normal mode
    add_poll(30, 0, 0, 0, 0, 0, 0, 1);         // no refresh due
    add_poll(30, 0, 0, 0, 0, 1, 0, 0);         // press inside debounce window
    add_poll(30, 5, -128, 0, 0, 0, 0, 0);
    add_poll(30, 1, -127, 0, 1, 0, 1, 1);
    add_poll(32'h7FFF_FFFF, -1, 127, 0, 0, 0, 0, 0);
    add_poll(5, 3, 3, 3, 0, 0, 0, 0);          // too early, ignored
    add_poll(29, 127, -128, 0, 0, 0, 0, 0);
    add_poll(32'h8000_0000, -127, 127, 0, 0, 1, 0, 0);

    // Low extremes, zero steering divisor
    run_phase(1, 1, 1, 0, 0, 1, 90);
    // High extremes, no display: the message never ends
    run_phase(65535, 65535, 65535, 65535, 127, 0, 70);
    // Mid settings, deflection beyond full scale
    run_phase(20, 100, 300, 50, 64, 1, 110);
    for (int k = 0; k < 2; k++)
      run_phase($urandom_range(1, 100), $urandom_range(1, 500), $urandom_range(1, 1000),
                $urandom_range(0, 300), $urandom_range(1, 127), 1, 60);

    // Last part without idling on either side
    wait_drained();
    calm = 1'b1;
    run_phase(30, 250, 2000, 150, 127, 1, 130);

    wait_drained();
    if (err_cnt == 0 && drive_exp_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/jdmc_pkg.sv
rtl/jdmc_if.sv
rtl/joystick_drive_mode_controller.sv
sim/joystick_drive_mode_controller_tb.sv
